// ===== design/scp_pkg.sv =====
// ---------------------------------------------------------------------------
// Sine / cosine approximation package
// Number formats, fold constants and polynomial coefficients shared by the
// argument reduction, the polynomial datapath and the top level.
// ---------------------------------------------------------------------------
package scp_pkg;

  localparam int ANGLE_FRAC_BITS  = 24;
  localparam int RESULT_FRAC_BITS = 30;

  localparam int ANGLE_W = 32;
  localparam int VALUE_W = 32;

  // Working format of the reduction: the angle magnitude widened by 32 bits.
  localparam int WF    = ANGLE_FRAC_BITS + 32;
  localparam int MW    = WF + 1;
  // Number of quotient bits of the reduction modulo 2*pi.
  localparam int QBITS = 29 - ANGLE_FRAC_BITS;

  localparam int Q30     = 30;
  localparam int X_W     = 31;
  localparam int X2_W    = 32;
  localparam int A_W     = 32;
  localparam int P_W     = 33;
  localparam int PROD_W  = A_W + X2_W;
  localparam int NSTEPS  = 3;

  localparam logic [63:0] PI_Q62          = 64'hC90FDAA22168C235;
  localparam logic [63:0] PI_W            = (PI_Q62 + (64'd1 << (61 - WF))) >> (62 - WF);
  localparam logic [63:0] HALF_PI_W       = (PI_Q62 + (64'd1 << (62 - WF))) >> (63 - WF);
  localparam logic [63:0] TWO_PI_W        = (PI_Q62 + (64'd1 << (60 - WF))) >> (61 - WF);
  localparam logic [63:0] THREE_HALF_PI_W = PI_W + HALF_PI_W;

  localparam logic signed [P_W-1:0] K1 = P_W'(1073734624);
  localparam logic signed [P_W-1:0] K2 = P_W'(-536776893);
  localparam logic signed [P_W-1:0] K3 = P_W'(44547129);
  localparam logic signed [P_W-1:0] K4 = P_W'(-1364951);

  // Constant added after each Horner product, innermost first.
  function automatic logic signed [P_W-1:0] horner_coef(input logic [1:0] step);
    logic signed [P_W-1:0] k;
    case (step)
      2'd0:    k = K3;
      2'd1:    k = K2;
      2'd2:    k = K1;
      default: k = K1;
    endcase
    return k;
  endfunction

  typedef struct packed {
    logic          positive;
    logic [MW-1:0] m;
  } scp_fold_t;

  typedef struct packed {
    logic           neg;
    logic [A_W-1:0] mag;
  } scp_res_t;

endpackage

// ===== design/scp_in_if.sv =====
// ---------------------------------------------------------------------------
// Angle channel
// Valid/ready channel carrying the function selector and the Q8.24 angle.
// ---------------------------------------------------------------------------
interface scp_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] angle;

  modport source (output valid, output func, output angle, input ready);
  modport sink   (input valid, input func, input angle, output ready);
endinterface

// ===== design/scp_out_if.sv =====
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the Q2.30 sine or cosine value.
// ---------------------------------------------------------------------------
interface scp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== design/scp_reduce.sv =====
// ---------------------------------------------------------------------------
// Argument reduction
// Takes the angle magnitude, reduces it modulo 2*pi one quotient bit per
// stage and folds the remainder into a 0..pi/2 magnitude with a sign.
// ---------------------------------------------------------------------------
module scp_reduce (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       in_func_i,
  input  logic signed [31:0]         in_angle_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output scp_pkg::scp_fold_t         out_data_o
);
  import scp_pkg::*;

  localparam int NS = QBITS + 2;

  typedef struct packed {
    logic        cosine;
    logic        neg;
    logic [63:0] num;
  } red_t;

  logic [NS-1:0] v_q, v_d, vin, en;
  red_t          red_q [QBITS+1];
  red_t          red_d [QBITS+1];
  scp_fold_t     fold_q, fold_d;
  logic [31:0]   mag;
  logic [63:0]   r;
  logic [63:0]   m_full;
  logic          pos;

  function automatic logic [63:0] absdiff(input logic [63:0] a, input logic [63:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // A stage takes new data when it is empty or its content moves on.
  assign en[NS-1] = !v_q[NS-1] || out_ready_i;
  for (genvar s = 0; s < NS - 1; s++) begin : g_en
    assign en[s] = !v_q[s] || en[s+1];
  end

  assign vin        = {v_q[NS-2:0], in_valid_i};
  assign in_ready_o = en[0];

  always_comb begin
    for (int s = 0; s < NS; s++) begin
      v_d[s] = en[s] ? vin[s] : v_q[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // The magnitude of the most negative angle, 2^31, still fits 32 bits.
  assign mag = in_angle_i[31] ? (~in_angle_i + 32'd1) : in_angle_i;

  always_comb begin
    red_d[0].cosine = in_func_i;
    red_d[0].neg    = in_angle_i[31];
    red_d[0].num    = {mag, 32'd0};
    for (int i = 1; i <= QBITS; i++) begin
      red_d[i] = red_q[i-1];
      if (red_q[i-1].num >= (TWO_PI_W << (QBITS - i))) begin
        red_d[i].num = red_q[i-1].num - (TWO_PI_W << (QBITS - i));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i <= QBITS; i++) begin
      if (en[i] && vin[i]) begin
        red_q[i] <= red_d[i];
      end
    end
  end

  assign r = red_q[QBITS].num;

  always_comb begin
    if (!red_q[QBITS].cosine) begin
      pos = !red_q[QBITS].neg;
      if (r < PI_W) begin
        m_full = absdiff(r, HALF_PI_W);
      end else begin
        m_full = absdiff(r, THREE_HALF_PI_W);
        pos    = !pos;
      end
    end else begin
      pos = 1'b1;
      if (r <= HALF_PI_W) begin
        m_full = r;
      end else if (r <= THREE_HALF_PI_W) begin
        m_full = absdiff(r, PI_W);
        pos    = 1'b0;
      end else begin
        m_full = TWO_PI_W - r;
      end
    end
    fold_d.positive = pos;
    fold_d.m        = m_full[MW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1] && vin[NS-1]) begin
      fold_q <= fold_d;
    end
  end

  assign out_valid_o = v_q[NS-1];
  assign out_data_o  = fold_q;

endmodule

// ===== design/scp_poly.sv =====
// ---------------------------------------------------------------------------
// Polynomial datapath
// Rounds the folded angle to Q30, squares it and runs three Horner steps,
// each as multiply, round-and-add and magnitude stages.
// ---------------------------------------------------------------------------
module scp_poly (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  scp_pkg::scp_fold_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output scp_pkg::scp_res_t   out_data_o
);
  import scp_pkg::*;

  localparam int NS = 2 + 3 * NSTEPS;

  localparam logic [MW:0]       M_RND   = (MW + 1)'(64'd1 << (WF - 31));
  localparam logic [2*X_W:0]    SQ_RND  = (2 * X_W + 1)'(64'd1 << (Q30 - 1));
  localparam logic [PROD_W-1:0] PR_RND  = PROD_W'(64'd1 << (Q30 - 1));
  localparam logic [A_W-1:0]    K4_MAG  = A_W'(-K4);
  localparam logic              K4_NEG  = K4[P_W-1];

  typedef struct packed {
    logic           pos;
    logic [X_W-1:0] x;
  } x_t;

  typedef struct packed {
    logic            pos;
    logic [X2_W-1:0] x2;
  } sq_t;

  typedef struct packed {
    logic              pos;
    logic [X2_W-1:0]   x2;
    logic              neg;
    logic [PROD_W-1:0] prod;
  } mul_t;

  typedef struct packed {
    logic                  pos;
    logic [X2_W-1:0]       x2;
    logic signed [P_W-1:0] p;
  } sum_t;

  typedef struct packed {
    logic            pos;
    logic [X2_W-1:0] x2;
    logic            neg;
    logic [A_W-1:0]  amag;
  } abs_t;

  logic [NS-1:0]     v_q, v_d, vin, en;
  x_t                x_q, x_d;
  sq_t               sq_q, sq_d;
  mul_t              mul_q [NSTEPS];
  mul_t              mul_d [NSTEPS];
  sum_t              sum_q [NSTEPS];
  sum_t              sum_d [NSTEPS];
  abs_t              abs_q [NSTEPS];
  abs_t              abs_d [NSTEPS];
  logic [MW:0]       m_sum;
  logic [2*X_W:0]    sq_sum;
  logic [PROD_W-1:0] rnd [NSTEPS];
  logic [P_W-1:0]    term [NSTEPS];
  logic [A_W-1:0]    src_mag [NSTEPS];
  logic              src_neg [NSTEPS];
  logic              src_pos [NSTEPS];
  logic [X2_W-1:0]   src_x2 [NSTEPS];

  assign en[NS-1] = !v_q[NS-1] || out_ready_i;
  for (genvar s = 0; s < NS - 1; s++) begin : g_en
    assign en[s] = !v_q[s] || en[s+1];
  end

  assign vin        = {v_q[NS-2:0], in_valid_i};
  assign in_ready_o = en[0];

  always_comb begin
    for (int s = 0; s < NS; s++) begin
      v_d[s] = en[s] ? vin[s] : v_q[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // Folded magnitude rounded to nearest into Q30, then squared into Q30.
  always_comb begin
    m_sum    = {1'b0, in_data_i.m} + M_RND;
    x_d.pos  = in_data_i.positive;
    x_d.x    = m_sum[WF-30 +: X_W];
    sq_sum   = {1'b0, (2 * X_W)'(x_q.x) * (2 * X_W)'(x_q.x)} + SQ_RND;
    sq_d.pos = x_q.pos;
    sq_d.x2  = sq_sum[Q30 +: X2_W];
  end

  // The innermost step multiplies the constant fourth coefficient.
  always_comb begin
    for (int j = 0; j < NSTEPS; j++) begin
      if (j == 0) begin
        src_mag[j] = K4_MAG;
        src_neg[j] = K4_NEG;
        src_pos[j] = sq_q.pos;
        src_x2[j]  = sq_q.x2;
      end else begin
        src_mag[j] = abs_q[j-1].amag;
        src_neg[j] = abs_q[j-1].neg;
        src_pos[j] = abs_q[j-1].pos;
        src_x2[j]  = abs_q[j-1].x2;
      end
      mul_d[j].pos  = src_pos[j];
      mul_d[j].x2   = src_x2[j];
      mul_d[j].neg  = src_neg[j];
      mul_d[j].prod = PROD_W'(src_mag[j]) * PROD_W'(src_x2[j]);

      // Rounding the magnitude gives ties away from zero on the signed product.
      rnd[j]       = (mul_q[j].prod + PR_RND) >> Q30;
      term[j]      = mul_q[j].neg ? (~rnd[j][P_W-1:0] + P_W'(1)) : rnd[j][P_W-1:0];
      sum_d[j].pos = mul_q[j].pos;
      sum_d[j].x2  = mul_q[j].x2;
      sum_d[j].p   = horner_coef(2'(j)) + $signed(term[j]);

      abs_d[j].pos  = sum_q[j].pos;
      abs_d[j].x2   = sum_q[j].x2;
      abs_d[j].neg  = sum_q[j].p[P_W-1];
      abs_d[j].amag = sum_q[j].p[P_W-1] ? A_W'(-sum_q[j].p) : A_W'(sum_q[j].p);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && vin[0]) begin
      x_q <= x_d;
    end
    if (en[1] && vin[1]) begin
      sq_q <= sq_d;
    end
    for (int j = 0; j < NSTEPS; j++) begin
      if (en[2+3*j] && vin[2+3*j]) begin
        mul_q[j] <= mul_d[j];
      end
      if (en[3+3*j] && vin[3+3*j]) begin
        sum_q[j] <= sum_d[j];
      end
      if (en[4+3*j] && vin[4+3*j]) begin
        abs_q[j] <= abs_d[j];
      end
    end
  end

  assign out_valid_o     = v_q[NS-1];
  assign out_data_o.neg  = abs_q[NSTEPS-1].neg ^ !abs_q[NSTEPS-1].pos;
  assign out_data_o.mag  = abs_q[NSTEPS-1].amag;

endmodule

// ===== design/sine_cosine_poly_approx_core.sv =====
// ---------------------------------------------------------------------------
// Sine / cosine polynomial approximation core
// Reduces a Q8.24 angle modulo 2*pi, folds it and evaluates a four-term
// even minimax polynomial, giving sine or cosine in Q2.30.
// ---------------------------------------------------------------------------
//  Channel   Direction   Payload                         Handshake
//  in_i      sink        func (1b), angle (Q8.24 s32)    valid / ready
//  out_o     source      value (Q2.30 s32)               valid / ready
//
//  One transaction is accepted in every cycle while the result channel is
//  not stalled; the path runs through an input register, one reduction
//  stage per quotient bit, a fold stage, eleven polynomial stages and the
//  output register.
//  rst_ni clears only the stage valid bits; payload registers are not reset.
//  Every stage holds while its successor is full and stalled, so bubbles are
//  squeezed out and nothing is lost or repeated.
// ---------------------------------------------------------------------------
module sine_cosine_poly_approx_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  scp_in_if.sink      in_i,
  scp_out_if.source   out_o
);
  import scp_pkg::*;

  localparam int RSH = Q30 - RESULT_FRAC_BITS;
  localparam logic [A_W:0] RND_HALF = ((A_W + 1)'(1) << RSH) >> 1;

  logic               red_valid, red_ready;
  scp_fold_t          red_data;
  logic               poly_valid, poly_ready;
  scp_res_t           poly_data;
  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] out_value_q, out_value_d;
  logic [A_W:0]       rounded;

  scp_reduce u_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_func_i   (in_i.func),
    .in_angle_i  (in_i.angle),
    .out_valid_o (red_valid),
    .out_ready_i (red_ready),
    .out_data_o  (red_data)
  );

  scp_poly u_poly (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (red_valid),
    .in_ready_o  (red_ready),
    .in_data_i   (red_data),
    .out_valid_o (poly_valid),
    .out_ready_i (poly_ready),
    .out_data_o  (poly_data)
  );

  assign poly_ready = !out_valid_q || out_o.ready;

  // Round the magnitude into the result format, then restore the sign.
  always_comb begin
    rounded     = ({1'b0, poly_data.mag} + RND_HALF) >> RSH;
    out_value_d = poly_data.neg ? (~rounded[VALUE_W-1:0] + VALUE_W'(1))
                                : rounded[VALUE_W-1:0];
    out_valid_d = poly_ready ? poly_valid : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (poly_ready && poly_valid) begin
      out_value_q <= out_value_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.value = out_value_q;

`ifndef SYNTH
  localparam logic signed [VALUE_W-1:0] VAL_LIM =
    VALUE_W'((64'd1 << RESULT_FRAC_BITS) + (64'd1 << (RESULT_FRAC_BITS - 8)));

  // Back-pressure can only reach the input once every stage is full.
  a_in_stall_needs_out_stall : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready)
  ) else $error("input stalled while the result channel is not stalled");

  // The polynomial stays within a hair of unit magnitude.
  a_value_in_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ($signed(out_o.value) <= VAL_LIM && $signed(out_o.value) >= -VAL_LIM)
  ) else $error("result magnitude exceeds the polynomial range");

  // A stage fed by the polynomial datapath only refills when it is free.
  a_out_refill : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(out_value_q))
  ) else $error("result register changed while stalled");
`endif

endmodule
